/* rtl/cfc_pkg.sv */
// Package for the command frame checker: register indexes, reset defaults,
// header and acknowledge byte constants. No dependencies.
`default_nettype none

package cfc_pkg;

  localparam int unsigned FRAME_LEN    = 16;
  localparam int unsigned PAYLOAD_LEN  = 10;
  localparam int unsigned PAYLOAD_POS  = 4;
  localparam int unsigned CHECK_POS    = 15;
  localparam int unsigned HEADER_LEN   = 4;
  localparam int unsigned ACK_LEN      = 4;

  localparam int unsigned CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER_LIMIT = 3'd0,
    REG_FREQ_LIMIT  = 3'd1,
    REG_DUTY_LIMIT  = 3'd2,
    REG_RISE_LIMIT  = 3'd3,
    REG_FALL_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACK_SYNC = 2'd0,
    ACK_CMD  = 2'd1,
    ACK_PAD  = 2'd2,
    ACK_END  = 2'd3
  } ack_idx_t;

  localparam logic [15:0] POWER_LIMIT_RST = 16'd100;
  localparam logic [15:0] FREQ_LIMIT_RST  = 16'd1000;
  localparam logic [15:0] DUTY_LIMIT_RST  = 16'd100;
  localparam logic [15:0] RISE_LIMIT_RST  = 16'd300;
  localparam logic [15:0] FALL_LIMIT_RST  = 16'd300;

  localparam logic [7:0] BYTE_SYNC    = 8'h01;
  localparam logic [7:0] BYTE_CMD_OK  = 8'h10;
  localparam logic [7:0] BYTE_CMD_BAD = 8'h90;
  localparam logic [7:0] BYTE_PAD     = 8'h00;
  localparam logic [7:0] BYTE_END     = 8'h0A;

  function automatic logic [7:0] header_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = BYTE_SYNC;
      2'd1:    b = BYTE_CMD_OK;
      2'd2:    b = BYTE_PAD;
      default: b = BYTE_END;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ack_byte_at(input ack_idx_t idx, input logic ok);
    logic [7:0] b;
    unique case (idx)
      ACK_SYNC: b = BYTE_SYNC;
      ACK_CMD:  b = ok ? BYTE_CMD_OK : BYTE_CMD_BAD;
      ACK_PAD:  b = BYTE_PAD;
      default:  b = BYTE_END;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/command_frame_checker.sv */
// Command frame checker top level: frame capture, check, decode and ack burst.
// Depends on cfc_pkg.
// Latency: first ack byte is valid the cycle after byte 15 of a frame is taken.
// Throughput: one byte per cycle; the four ack bytes leave one per cycle when
// out_stall is low. Byte 15 of the next frame waits until the previous burst
// has gone out; bytes 0..14 are taken meanwhile.
// Reset (rst, synchronous): byte count, held values and burst cleared, limits
// set to their defaults.
`default_nettype none

module command_frame_checker
  import cfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [7:0]           rx_byte,

  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [7:0]           ack_byte,
  output      logic                 ack_last,
  output      logic                 frame_ok,
  output      logic [15:0]          power,
  output      logic [15:0]          frequency,
  output      logic [15:0]          duty,
  output      logic [15:0]          rise_time,
  output      logic [15:0]          fall_time,

  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic [15:0] power_limit;
  logic [15:0] freq_limit;
  logic [15:0] duty_limit;
  logic [15:0] rise_limit;
  logic [15:0] fall_limit;

  logic [3:0]  byte_count;
  logic        hdr_ok;
  logic [7:0]  sum;
  logic [7:0]  payload [PAYLOAD_LEN];

  logic        burst;
  ack_idx_t    ack_idx;
  logic        ok_reg;

  logic        in_acc;
  logic        out_acc;
  logic        frame_end;
  logic        burst_done;
  logic        good;
  logic [15:0] v_power, v_freq, v_duty, v_rise, v_fall;

  assign cfg_ready  = 1'b1;
  assign out_acc    = out_valid && !out_stall;
  assign burst_done = out_acc && (ack_idx == ACK_END);
  assign in_stall   = (byte_count == 4'(CHECK_POS)) && burst && !burst_done;
  assign in_acc     = in_valid && !in_stall;
  assign frame_end  = in_acc && (byte_count == 4'(CHECK_POS));

  // header flag and checksum are built as the frame arrives
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (byte_count < 4'(HEADER_LEN)) begin
        hdr_ok <= ((byte_count == 4'd0) ? 1'b1 : hdr_ok) &&
                  (rx_byte == header_byte(byte_count[1:0]));
      end
      if (byte_count == 4'(PAYLOAD_POS)) begin
        sum <= rx_byte;
      end else if (byte_count < 4'(PAYLOAD_POS + PAYLOAD_LEN) &&
                   byte_count > 4'(PAYLOAD_POS)) begin
        sum <= sum + rx_byte;
      end
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
        if (byte_count == 4'(PAYLOAD_POS + i)) begin
          payload[i] <= rx_byte;
        end
      end
    end
  end

  always_comb begin
    good    = hdr_ok && (sum == rx_byte);
    v_power = {payload[0], payload[1]};
    v_freq  = {payload[2], payload[3]};
    v_duty  = {payload[4], payload[5]};
    v_rise  = {payload[6], payload[7]};
    v_fall  = {payload[8], payload[9]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      power      <= '0;
      frequency  <= '0;
      duty       <= '0;
      rise_time  <= '0;
      fall_time  <= '0;
      burst      <= 1'b0;
      ack_idx    <= ACK_SYNC;
      ok_reg     <= 1'b0;
    end else begin
      if (in_acc) begin
        byte_count <= byte_count + 4'd1;
      end
      if (out_acc) begin
        ack_idx <= ack_idx_t'(ack_idx + 2'd1);
        if (ack_idx == ACK_END) begin
          burst <= 1'b0;
        end
      end
      if (frame_end) begin
        burst   <= 1'b1;
        ack_idx <= ACK_SYNC;
        ok_reg  <= good;
        if (good) begin
          power     <= (v_power > power_limit) ? power_limit : v_power;
          frequency <= (v_freq > freq_limit) ? 16'd0 : v_freq;
          duty      <= (v_duty > duty_limit) ? duty_limit : v_duty;
          rise_time <= (v_rise > rise_limit) ? 16'd0 : v_rise;
          fall_time <= (v_fall > fall_limit) ? 16'd0 : v_fall;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_limit <= POWER_LIMIT_RST;
      freq_limit  <= FREQ_LIMIT_RST;
      duty_limit  <= DUTY_LIMIT_RST;
      rise_limit  <= RISE_LIMIT_RST;
      fall_limit  <= FALL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POWER_LIMIT: power_limit <= cfg_data;
        REG_FREQ_LIMIT:  freq_limit  <= cfg_data;
        REG_DUTY_LIMIT:  duty_limit  <= cfg_data;
        REG_RISE_LIMIT:  rise_limit  <= cfg_data;
        REG_FALL_LIMIT:  fall_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid = burst;
  assign ack_byte  = ack_byte_at(ack_idx, ok_reg);
  assign ack_last  = (ack_idx == ACK_END);
  assign frame_ok  = ok_reg;

  // frame end always starts a burst at its first byte
  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    frame_end |=> out_valid && (ack_byte == BYTE_SYNC) && !ack_last)
    else $error("ack burst did not start after frame end");

  // held values only move on a frame end
  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !frame_end |=> $stable(power) && $stable(frequency) && $stable(duty) &&
                   $stable(rise_time) && $stable(fall_time))
    else $error("held values changed outside a frame end");

  // idle output keeps the ack index at the first byte
  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> (ack_idx == ACK_SYNC))
    else $error("ack index not at start while idle");

  // last byte taken with no new frame end empties the burst
  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    burst_done && !frame_end |=> !out_valid)
    else $error("burst continued past the last ack byte");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for command_frame_checker: directed frame table, then random
// frames and noise bytes under random sender gaps and receiver stalls.
// Depends on cfc_pkg and the command_frame_checker RTL.
`timescale 1ns / 1ps

module tb;
  import cfc_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_BYTES = 200;
  localparam int N_CASES      = 12;

  typedef struct packed {
    logic [15:0] power;
    logic [15:0] frequency;
    logic [15:0] duty;
    logic [15:0] rise;
    logic [15:0] fall;
  } held_t;

  typedef struct packed {
    logic [7:0] ack_byte;
    logic       ack_last;
    logic       frame_ok;
    held_t      held;
  } ack_t;

  typedef struct {
    logic        set_lim;
    logic [15:0] lim;
    logic        junk_cfg;
    logic [31:0] hdr_xor;
    held_t       vals;
    logic [7:0]  spare;
    logic [7:0]  sum_err;
    logic        typed;
    logic        exp_ok;
    held_t       exp_held;
  } frame_case_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           rx_byte;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           ack_byte;
  logic                 ack_last;
  logic                 frame_ok;
  logic [15:0]          power;
  logic [15:0]          frequency;
  logic [15:0]          duty;
  logic [15:0]          rise_time;
  logic [15:0]          fall_time;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // frame tracking and limits as the block should hold them
  logic [15:0] lim_power = POWER_LIMIT_RST;
  logic [15:0] lim_freq  = FREQ_LIMIT_RST;
  logic [15:0] lim_duty  = DUTY_LIMIT_RST;
  logic [15:0] lim_rise  = RISE_LIMIT_RST;
  logic [15:0] lim_fall  = FALL_LIMIT_RST;
  logic [3:0]  frame_pos = 4'd0;
  logic [7:0]  frame_buf [16];
  held_t       kept = '0;

  logic        typed_pending = 1'b0;
  logic        typed_ok;
  held_t       typed_held;

  ack_t        pending_acks [$];
  frame_case_t dir_cases [N_CASES];
  int          errors = 0;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;

  command_frame_checker uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ack_byte  (ack_byte),
    .ack_last  (ack_last),
    .frame_ok  (frame_ok),
    .power     (power),
    .frequency (frequency),
    .duty      (duty),
    .rise_time (rise_time),
    .fall_time (fall_time),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void take_rx_byte(input logic [7:0] b);
    logic [3:0]  pos;
    logic [7:0]  sum;
    logic        good;
    logic [15:0] w;
    ack_t        a;
    int          k;
    pos = frame_pos;
    frame_buf[pos] = b;
    frame_pos = pos + 4'd1;
    if (pos != 4'd15) return;
    sum = 8'd0;
    for (k = 4; k <= 13; k++) sum += frame_buf[k];
    good = ({frame_buf[0], frame_buf[1], frame_buf[2], frame_buf[3]} ==
            {BYTE_SYNC, BYTE_CMD_OK, BYTE_PAD, BYTE_END}) && (sum == frame_buf[15]);
    if (typed_pending) begin
      good = typed_ok;
      kept = typed_held;
      typed_pending = 1'b0;
    end else if (good) begin
      w = {frame_buf[4], frame_buf[5]};
      kept.power = (w > lim_power) ? lim_power : w;
      w = {frame_buf[6], frame_buf[7]};
      kept.frequency = (w > lim_freq) ? 16'd0 : w;
      w = {frame_buf[8], frame_buf[9]};
      kept.duty = (w > lim_duty) ? lim_duty : w;
      w = {frame_buf[10], frame_buf[11]};
      kept.rise = (w > lim_rise) ? 16'd0 : w;
      w = {frame_buf[12], frame_buf[13]};
      kept.fall = (w > lim_fall) ? 16'd0 : w;
    end
    for (k = 0; k < ACK_LEN; k++) begin
      case (ack_idx_t'(k))
        ACK_SYNC: a.ack_byte = BYTE_SYNC;
        ACK_CMD:  a.ack_byte = good ? BYTE_CMD_OK : BYTE_CMD_BAD;
        ACK_PAD:  a.ack_byte = BYTE_PAD;
        default:  a.ack_byte = BYTE_END;
      endcase
      a.ack_last = (ack_idx_t'(k) == ACK_END);
      a.frame_ok = good;
      a.held = kept;
      pending_acks.push_back(a);
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function automatic logic [15:0] pick_value(input logic [15:0] lim);
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      2:       v = lim;
      3:       v = lim + 16'd1;
      4:       v = lim - 16'd1;
      5:       v = 16'($urandom);
      default: v = 16'($urandom_range(0, 1200));
    endcase
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    take_rx_byte(b);
  endtask

  task automatic send_frame(input logic [31:0] hdr_xor, input held_t vals,
                            input logic [7:0] spare, input logic [7:0] sum_err);
    logic [7:0] fb [16];
    logic [7:0] sum;
    int         k;
    {fb[0], fb[1], fb[2], fb[3]} = {BYTE_SYNC, BYTE_CMD_OK, BYTE_PAD, BYTE_END} ^ hdr_xor;
    {fb[4], fb[5], fb[6], fb[7], fb[8], fb[9], fb[10], fb[11], fb[12], fb[13]} = vals;
    fb[14] = spare;
    sum = 8'd0;
    for (k = 4; k <= 13; k++) sum += fb[k];
    fb[15] = sum + sum_err;
    for (k = 0; k < FRAME_LEN; k++) send_byte(fb[k]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_POWER_LIMIT: lim_power = v;
      REG_FREQ_LIMIT:  lim_freq = v;
      REG_DUTY_LIMIT:  lim_duty = v;
      REG_RISE_LIMIT:  lim_rise = v;
      REG_FALL_LIMIT:  lim_fall = v;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_limits(input logic [15:0] v);
    write_reg(REG_POWER_LIMIT, v);
    write_reg(REG_FREQ_LIMIT, v);
    write_reg(REG_DUTY_LIMIT, v);
    write_reg(REG_RISE_LIMIT, v);
    write_reg(REG_FALL_LIMIT, v);
  endtask

  task automatic random_config();
    int          n;
    logic [15:0] v;
    wait_drained();
    n = $urandom_range(1, 5);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       v = 16'h0000;
        1:       v = 16'hFFFF;
        2:       v = 16'($urandom);
        default: v = 16'($urandom_range(0, 1200));
      endcase
      // indexes above the last register are written too and must be ignored
      write_reg(CFG_IDX_W'($urandom_range(0, 7)), v);
    end
  endtask

  task automatic send_random_frame();
    logic [31:0] hx;
    logic [7:0]  err;
    held_t       v;
    int          r;
    hx = '0;
    err = '0;
    while (frame_pos != 4'd0) send_byte(8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 12)
      hx = 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
    else if (r < 22)
      err = 8'($urandom_range(1, 255));
    v.power = pick_value(lim_power);
    v.frequency = pick_value(lim_freq);
    v.duty = pick_value(lim_duty);
    v.rise = pick_value(lim_rise);
    v.fall = pick_value(lim_fall);
    send_frame(hx, v, 8'($urandom), err);
  endtask

  // set_lim lim junk_cfg hdr_xor vals spare sum_err typed exp_ok exp_held
  initial begin
    dir_cases[0]  = '{1'b0, 16'd0, 1'b0, 32'h0, {5{16'h0000}}, 8'h00, 8'h00,
                      1'b1, 1'b1, {5{16'h0000}}};
    dir_cases[1]  = '{1'b0, 16'd0, 1'b0, 32'h0080_0000,
                      {16'h1234, 16'h0056, 16'h0042, 16'h00C8, 16'h0100}, 8'h5A, 8'h00,
                      1'b1, 1'b0, {5{16'h0000}}};
    dir_cases[2]  = '{1'b0, 16'd0, 1'b0, 32'h0, {16'd100, 16'd1000, 16'd100, 16'd300, 16'd300},
                      8'h00, 8'h00, 1'b1, 1'b1, {16'd100, 16'd1000, 16'd100, 16'd300, 16'd300}};
    dir_cases[3]  = '{1'b0, 16'd0, 1'b0, 32'h0, {5{16'hFFFF}}, 8'hFF, 8'h00,
                      1'b1, 1'b1, {16'd100, 16'd0, 16'd100, 16'd0, 16'd0}};
    dir_cases[4]  = '{1'b0, 16'd0, 1'b0, 32'h0, {16'd50, 16'd500, 16'd50, 16'd150, 16'd150},
                      8'h00, 8'h01, 1'b1, 1'b0, {16'd100, 16'd0, 16'd100, 16'd0, 16'd0}};
    dir_cases[5]  = '{1'b0, 16'd0, 1'b0, 32'h0, {16'd101, 16'd1001, 16'd101, 16'd301, 16'd301},
                      8'h00, 8'h00, 1'b1, 1'b1, {16'd100, 16'd0, 16'd100, 16'd0, 16'd0}};
    dir_cases[6]  = '{1'b1, 16'd0, 1'b0, 32'h0, {5{16'h0000}}, 8'h00, 8'h00,
                      1'b1, 1'b1, {5{16'h0000}}};
    dir_cases[7]  = '{1'b0, 16'd0, 1'b0, 32'h0, {5{16'h0001}}, 8'h00, 8'h00,
                      1'b1, 1'b1, {5{16'h0000}}};
    dir_cases[8]  = '{1'b1, 16'hFFFF, 1'b0, 32'h0, {5{16'hFFFF}}, 8'h00, 8'h00,
                      1'b1, 1'b1, {5{16'hFFFF}}};
    dir_cases[9]  = '{1'b0, 16'd0, 1'b1, 32'h0,
                      {16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 16'h0001}, 8'h80, 8'h00,
                      1'b0, 1'b0, {5{16'h0000}}};
    dir_cases[10] = '{1'b1, 16'd500, 1'b0, 32'h0100_0000,
                      {16'd600, 16'd400, 16'd500, 16'd501, 16'd0}, 8'h00, 8'h00,
                      1'b0, 1'b0, {5{16'h0000}}};
    dir_cases[11] = '{1'b0, 16'd0, 1'b0, 32'h0,
                      {16'd600, 16'd400, 16'd500, 16'd501, 16'd0}, 8'h33, 8'h00,
                      1'b0, 1'b0, {5{16'h0000}}};
  end

  initial begin
    int target;
    int r;
    int i;
    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= 16'h0000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_CASES; i++) begin
      if (dir_cases[i].set_lim) write_all_limits(dir_cases[i].lim);
      if (dir_cases[i].junk_cfg) begin
        write_reg(3'd5, 16'h0000);
        write_reg(3'd6, 16'h1234);
        write_reg(3'd7, 16'hFFFF);
      end
      typed_pending = dir_cases[i].typed;
      typed_ok = dir_cases[i].exp_ok;
      typed_held = dir_cases[i].exp_held;
      send_frame(dir_cases[i].hdr_xor, dir_cases[i].vals, dir_cases[i].spare,
                 dir_cases[i].sum_err);
      wait_drained();
    end
    // knock the stream off frame alignment
    repeat (7) send_byte(8'($urandom));

    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 6)
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
      else if (r < 10)
        wait_drained();
      else if (r < 16)
        random_config();
      else
        send_random_frame();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // receiver stall pattern rotates through four modes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case (cycle_count[8:7])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 1) == 1);
      2'd2:    out_stall <= (cycle_count[1:0] != 2'd0);
      default: out_stall <= ($urandom_range(0, 4) == 0);
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin : ack_check
    ack_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_acks.size() == 0) begin
        errors++;
        $display("%0t: unexpected ack transaction, expected none, actual ack_byte %h",
                 $time, ack_byte);
      end else begin
        want = pending_acks.pop_front();
        check_field("ack_byte", 16'(want.ack_byte), 16'(ack_byte));
        check_field("ack_last", 16'(want.ack_last), 16'(ack_last));
        check_field("frame_ok", 16'(want.frame_ok), 16'(frame_ok));
        check_field("power", want.held.power, power);
        check_field("frequency", want.held.frequency, frequency);
        check_field("duty", want.held.duty, duty);
        check_field("rise_time", want.held.rise, rise_time);
        check_field("fall_time", want.held.fall, fall_time);
      end
    end
  end

endmodule
